[src/ftp_port_pasv_scanner_defines.svh]
// assertion macros for the ftp port/pasv scanner
`ifndef FTP_PORT_PASV_SCANNER_DEFINES_SVH
`define FTP_PORT_PASV_SCANNER_DEFINES_SVH

// property checked on every clock outside reset
`define FPPS_CHECK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define FPPS_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/fpps_pkg.sv]
// types, pattern tables and match helpers for the ftp port/pasv scanner
package fpps_pkg;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_PASV  = 2'd1,
		KIND_PORT  = 2'd2,
		KIND_REPLY = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       from_server;
		logic       established;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] address;
		logic [15:0] port;
		logic [15:0] text_start;
		logic [15:0] text_end;
		logic        pasv_pending;
	} result_t;

	localparam int SRV_DEPTH  = 27;
	localparam int CLI_DEPTH  = 5;
	localparam int PASV_DEPTH = 6;
	localparam int NUM_COUNT  = 6;

	localparam logic [4:0] SRV_LEN    = 5'(SRV_DEPTH);
	localparam logic [4:0] CLI_LEN    = 5'(CLI_DEPTH);
	localparam logic [2:0] PASV_LEN   = 3'(PASV_DEPTH);
	localparam logic [4:0] IN_NUMBERS = 5'd31;
	localparam logic [2:0] LAST_NUM   = 3'(NUM_COUNT - 1);

	localparam logic [7:0] CHAR_CR    = 8'h0d;
	localparam logic [7:0] CHAR_LF    = 8'h0a;
	localparam logic [7:0] CHAR_COMMA = 8'h2c;
	localparam logic [7:0] CHAR_CLOSE = 8'h29;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// patterns are stored lower case, the byte is folded before compare
	localparam logic [7:0] SRV_PAT [SRV_DEPTH] = '{
		"2", "2", "7", " ", "e", "n", "t", "e", "r", "i", "n", "g", " ", "p",
		"a", "s", "s", "i", "v", "e", " ", "m", "o", "d", "e", " ", "("
	};
	localparam logic [7:0] CLI_PAT [CLI_DEPTH] = '{"p", "o", "r", "t", " "};
	localparam logic [7:0] PASV_PAT [PASV_DEPTH] = '{"p", "a", "s", "v", CHAR_CR, CHAR_LF};

	function automatic logic [7:0] fold(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= "A" && c <= "Z") begin
			r = c + 8'd32;
		end
		return r;
	endfunction

	// "227 ..." only overlaps itself in its leading "22"
	function automatic logic [4:0] adv_srv(input logic [4:0] j, input logic [7:0] c);
		logic [4:0] jj;
		logic [4:0] r;
		jj = (j < SRV_LEN) ? j : 5'd0;
		if (SRV_PAT[jj] == c) begin
			r = jj + 5'd1;
		end else if (jj == 5'd2 && c == SRV_PAT[0]) begin
			r = 5'd2;
		end else if (c == SRV_PAT[0]) begin
			r = 5'd1;
		end else begin
			r = 5'd0;
		end
		return r;
	endfunction

	function automatic logic [4:0] adv_cli(input logic [4:0] j, input logic [7:0] c);
		logic [2:0] jj;
		logic [4:0] r;
		jj = (j < CLI_LEN) ? j[2:0] : 3'd0;
		if (CLI_PAT[jj] == c) begin
			r = {2'b00, jj} + 5'd1;
		end else if (c == CLI_PAT[0]) begin
			r = 5'd1;
		end else begin
			r = 5'd0;
		end
		return r;
	endfunction

	function automatic logic [2:0] adv_pasv(input logic [2:0] j, input logic [7:0] c);
		logic [2:0] jj;
		logic [2:0] r;
		jj = (j < PASV_LEN) ? j : 3'd0;
		if (PASV_PAT[jj] == c) begin
			r = jj + 3'd1;
		end else if (c == PASV_PAT[0]) begin
			r = 3'd1;
		end else begin
			r = 3'd0;
		end
		return r;
	endfunction

endpackage

[src/ftp_port_pasv_scanner.sv]
// top level of the ftp control-channel port/pasv scanner
// Scans one FTP control flow a payload byte per clock and, on the last byte of
// each packet, hands out one result: PASV seen, PORT parsed, 227 reply parsed or
// none, with the address, port and text offsets. Bytes are taken back to back at
// one per clock while the input does not stall; a byte is held in the input
// register while the match state is updated and, on the last byte, the result is
// loaded into the output register, from which it is offered. The input stalls
// only when a last byte is waiting and the output register is still held by the
// previous result.
module ftp_port_pasv_scanner (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  fpps_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output fpps_pkg::result_t result
);
	import fpps_pkg::*;
	`include "ftp_port_pasv_scanner_defines.svh"

	item_t   item_s1;
	logic    valid_s1;
	logic    fire_s1;
	logic    out_free;
	logic    accept;
	result_t scan_res;
	result_t result_q;
	logic    result_valid_q;

	assign out_free   = !result_valid_q || !result_stall;
	assign fire_s1    = valid_s1 && (!item_s1.last_byte || out_free);
	assign item_stall = valid_s1 && !fire_s1;
	assign accept     = item_valid && !item_stall;

	fpps_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (fire_s1),
		.item   (item_s1),
		.res    (scan_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire_s1) begin
				valid_s1 <= 1'b0;
			end
			if (fire_s1 && item_s1.last_byte) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		if (fire_s1 && item_s1.last_byte) begin
			result_q <= scan_res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`FPPS_CHECK(a_stall_has_item, !item_stall || valid_s1, "input stalled with empty stage")
	`FPPS_CHECK(a_empty_fields,
		!result_valid || result.kind == KIND_PORT || result.kind == KIND_REPLY
		|| (result.address == 32'd0 && result.port == 16'd0 && result.text_start == 16'd0
		&& result.text_end == 16'd0), "address fields set on a result without address")
	`FPPS_CHECK(a_pasv_sets_flag, !result_valid || result.kind != KIND_PASV
		|| result.pasv_pending, "pasv result without pending flag")
	`FPPS_CHECK(a_reply_clears_flag, !result_valid || result.kind != KIND_REPLY
		|| !result.pasv_pending, "reply result left pending flag set")
	`FPPS_CHECK_NEXT(a_last_loads_result, fire_s1 && item_s1.last_byte, result_valid,
		"last byte did not produce a result")

endmodule

[src/fpps_scan.sv]
// per-flow scan state and byte-at-a-time match logic
module fpps_scan (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  fpps_pkg::item_t  item,
	output fpps_pkg::result_t res
);
	import fpps_pkg::*;

	logic        flag_q, flag_d;
	logic [15:0] offset_q, offset_d;
	logic [4:0]  prefix_q, prefix_d;
	logic [2:0]  pasv_pos_q, pasv_pos_d;
	logic [2:0]  idx_q, idx_d;
	logic [7:0]  acc_q, acc_d;
	logic [7:0]  nums_q [NUM_COUNT];
	logic [7:0]  nums_d [NUM_COUNT];
	kind_t       found_q, found_d;
	logic [15:0] start_q, start_d;
	logic [15:0] end_q, end_d;

	logic [7:0]  raw;
	logic [7:0]  c;
	logic        srv;
	logic        in_num;
	logic        digit;
	logic [7:0]  sep;
	logic [7:0]  acc_x10;
	logic [4:0]  j;
	logic [4:0]  pos;
	logic        full;
	kind_t       kind;

	assign raw     = item.payload_byte;
	assign c       = fold(item.payload_byte);
	assign srv     = item.from_server;
	assign in_num  = (prefix_q == IN_NUMBERS);
	assign digit   = (raw >= CHAR_ZERO) && (raw <= CHAR_NINE);
	assign sep     = (idx_q < LAST_NUM) ? CHAR_COMMA : (srv ? CHAR_CLOSE : CHAR_CR);
	assign acc_x10 = {acc_q[4:0], 3'b000} + {acc_q[6:0], 1'b0};
	assign j       = in_num ? 5'd0 : prefix_q;
	assign pos     = srv ? adv_srv(j, c) : adv_cli(j, c);
	assign full    = srv ? (pos == SRV_LEN) : (pos == CLI_LEN);

	always_comb begin
		flag_d     = flag_q;
		offset_d   = offset_q + 16'd1;
		prefix_d   = prefix_q;
		pasv_pos_d = pasv_pos_q;
		idx_d      = idx_q;
		acc_d      = acc_q;
		nums_d     = nums_q;
		found_d    = found_q;
		start_d    = start_q;
		end_d      = end_q;
		kind       = KIND_NONE;

		if (pasv_pos_q < PASV_LEN) begin
			pasv_pos_d = adv_pasv(pasv_pos_q, c);
		end

		if (found_q == KIND_NONE) begin
			if (in_num && digit) begin
				acc_d = acc_x10 + (raw - CHAR_ZERO);
			end else if (in_num && idx_q <= LAST_NUM && raw == sep) begin
				nums_d[idx_q] = acc_q;
				acc_d         = 8'd0;
				if (idx_q == LAST_NUM) begin
					found_d  = srv ? KIND_REPLY : KIND_PORT;
					end_d    = offset_q;
					prefix_d = 5'd0;
				end else begin
					idx_d = idx_q + 3'd1;
				end
			end else if (full) begin
				// prefix complete, number fields follow
				prefix_d = IN_NUMBERS;
				idx_d    = 3'd0;
				acc_d    = 8'd0;
				start_d  = offset_q + 16'd1;
			end else begin
				prefix_d = pos;
			end
		end

		// kind and flag are only decided on the last byte of a packet
		if (item.last_byte && item.established) begin
			if (!srv) begin
				if (pasv_pos_d == PASV_LEN) begin
					kind   = KIND_PASV;
					flag_d = 1'b1;
				end else if (found_d == KIND_PORT) begin
					kind = KIND_PORT;
				end
			end else if (flag_q && found_d == KIND_REPLY) begin
				kind   = KIND_REPLY;
				flag_d = 1'b0;
			end
		end

		res.kind         = kind;
		res.pasv_pending = flag_d;
		if (kind == KIND_PORT || kind == KIND_REPLY) begin
			res.address    = {nums_d[3], nums_d[2], nums_d[1], nums_d[0]};
			res.port       = {nums_d[5], nums_d[4]};
			res.text_start = start_d;
			res.text_end   = end_d;
		end else begin
			res.address    = 32'd0;
			res.port       = 16'd0;
			res.text_start = 16'd0;
			res.text_end   = 16'd0;
		end

		// end of packet: flag persists, everything else starts over
		if (item.last_byte) begin
			if (!item.established) begin
				flag_d = flag_q;
			end
			offset_d   = 16'd0;
			prefix_d   = 5'd0;
			pasv_pos_d = 3'd0;
			idx_d      = 3'd0;
			acc_d      = 8'd0;
			for (int i = 0; i < NUM_COUNT; i++) begin
				nums_d[i] = 8'd0;
			end
			found_d = KIND_NONE;
			start_d = 16'd0;
			end_d   = 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q     <= 1'b0;
			offset_q   <= 16'd0;
			prefix_q   <= 5'd0;
			pasv_pos_q <= 3'd0;
			idx_q      <= 3'd0;
			acc_q      <= 8'd0;
			for (int i = 0; i < NUM_COUNT; i++) begin
				nums_q[i] <= 8'd0;
			end
			found_q <= KIND_NONE;
			start_q <= 16'd0;
			end_q   <= 16'd0;
		end else if (en) begin
			flag_q     <= flag_d;
			offset_q   <= offset_d;
			prefix_q   <= prefix_d;
			pasv_pos_q <= pasv_pos_d;
			idx_q      <= idx_d;
			acc_q      <= acc_d;
			nums_q     <= nums_d;
			found_q    <= found_d;
			start_q    <= start_d;
			end_q      <= end_d;
		end
	end

endmodule
